@@ rtl/raz_pkg.sv @@
// ----------------------------------------------------------------------------
// raz_pkg
// Shared types and constants of the ratiometric auto-zero scaler.
// ----------------------------------------------------------------------------
package raz_pkg;

  // Register map, word index taken from paddr[3:2].
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;
  localparam logic [1:0]  REG_VREF  = 2'd0;
  localparam logic [1:0]  REG_UPPER = 2'd1;
  localparam logic [1:0]  REG_LOWER = 2'd2;
  localparam logic [1:0]  REG_GAIN  = 2'd3;

  // Range group codes. The unused code scales like hundred, with no saturation.
  localparam logic [1:0]  GAIN_ONE      = 2'd0;
  localparam logic [1:0]  GAIN_TEN      = 2'd1;
  localparam logic [1:0]  GAIN_HUNDRED  = 2'd2;
  localparam logic [1:0]  GAIN_SATURATE = 2'd3;

  localparam int unsigned VALUE_W = 40;
  localparam int unsigned LIMIT_W = 32;

  // Side band that travels with every request through the pipeline.
  typedef struct packed {
    logic vld;
    logic zero;
    logic neg;
  } raz_tag_t;

endpackage

@@ rtl/raz_div.sv @@
// ----------------------------------------------------------------------------
// raz_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module raz_div #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  raz_pkg::raz_tag_t        tag_i,
  input  logic [COUNT_BITS+31:0]   dividend_i,
  input  logic [COUNT_BITS-1:0]    divisor_i,
  output raz_pkg::raz_tag_t        tag_o,
  output logic [COUNT_BITS+31:0]   quotient_o
);

  localparam int unsigned DW = COUNT_BITS + 32;
  localparam int unsigned CB = COUNT_BITS;

  raz_pkg::raz_tag_t tag_q [DW];
  logic [CB-1:0]     rem_q [DW];
  logic [DW-1:0]     dq_q  [DW];
  logic [CB-1:0]     dv_q  [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    raz_pkg::raz_tag_t tag_in;
    logic [CB-1:0]     rem_in;
    logic [DW-1:0]     dq_in;
    logic [CB-1:0]     dv_in;
    logic [CB:0]       sh;
    logic [CB:0]       diff;
    logic              ge;
    logic [CB-1:0]     rem_d;
    logic [DW-1:0]     dq_d;

    if (i == 0) begin : g_first
      assign tag_in = tag_i;
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign dv_in  = divisor_i;
    end else begin : g_next
      assign tag_in = tag_q[i-1];
      assign rem_in = rem_q[i-1];
      assign dq_in  = dq_q[i-1];
      assign dv_in  = dv_q[i-1];
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    assign sh    = {rem_in, dq_in[DW-1]};
    assign diff  = sh - {1'b0, dv_in};
    assign ge    = (sh >= {1'b0, dv_in});
    assign rem_d = ge ? diff[CB-1:0] : sh[CB-1:0];
    assign dq_d  = {dq_in[DW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[i] <= '0;
      end else if (en_i) begin
        tag_q[i] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        dq_q[i]  <= dq_d;
        dv_q[i]  <= dv_in;
      end
    end
  end

  assign tag_o      = tag_q[DW-1];
  assign quotient_o = dq_q[DW-1];

endmodule

@@ rtl/ratiometric_autozero_scaler_top.sv @@
// ----------------------------------------------------------------------------
// ratiometric_autozero_scaler_top
// Auto-zero corrected ratiometric reading with clamp and range scaling.
// ----------------------------------------------------------------------------
// One request carries four integrator counts and yields one result:
// vref*(signal-signal_zero)/(reference-reference_zero) in signed fixed point,
// truncated toward zero, clamped to the limit registers and scaled by 1, 10 or
// 100. A request is accepted every cycle while the output is taken. A result
// passes stage 0, stage 1, the divider, the sign, clamp and scale stages and
// the output register; the divider resolves one quotient bit per stage over
// COUNT_BITS+32 stages. A two-entry output buffer lets requests keep entering
// while one result waits. Configuration must be written only while no
// request is in flight.
module ratiometric_autozero_scaler_top #(
  parameter int unsigned COUNT_BITS    = 24,
  parameter int unsigned FRACTION_BITS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COUNT_BITS-1:0]             signal_count_i,
  input  logic [COUNT_BITS-1:0]             signal_zero_count_i,
  input  logic [COUNT_BITS-1:0]             reference_zero_count_i,
  input  logic [COUNT_BITS-1:0]             reference_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [raz_pkg::VALUE_W-1:0] value_o,
  output logic                              zero_reference_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [raz_pkg::PADDR_W-1:0]       paddr,
  input  logic [raz_pkg::PDATA_W-1:0]       pwdata,
  output logic [raz_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned DW = COUNT_BITS + 32;
  localparam int unsigned QW = DW + 1;
  localparam int unsigned VW = raz_pkg::VALUE_W;
  localparam int unsigned LW = raz_pkg::LIMIT_W;

  localparam longint ONE       = longint'(1) << FRACTION_BITS;
  localparam longint VREF_INIT = -((28 * ONE + 5) / 10);
  localparam longint LIM_INIT  = (32 * ONE + 5) / 10;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [LW-1:0] vref_q, upper_q, lower_q;
  logic [LW-1:0]        vmag_q;
  logic                 vneg_q;
  logic [1:0]           gain_q;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q  <= LW'(VREF_INIT);
      vmag_q  <= LW'(-VREF_INIT);
      vneg_q  <= 1'b1;
      upper_q <= LW'(LIM_INIT);
      lower_q <= LW'(-LIM_INIT);
      gain_q  <= raz_pkg::GAIN_ONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        raz_pkg::REG_VREF: begin
          vref_q <= pwdata;
          vneg_q <= pwdata[LW-1];
          // The magnitude of the most negative value is still exact unsigned.
          vmag_q <= pwdata[LW-1] ? (LW'(0) - pwdata) : pwdata;
        end
        raz_pkg::REG_UPPER: upper_q <= pwdata;
        raz_pkg::REG_LOWER: lower_q <= pwdata;
        raz_pkg::REG_GAIN:  gain_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      raz_pkg::REG_VREF:  prdata = vref_q;
      raz_pkg::REG_UPPER: prdata = upper_q;
      raz_pkg::REG_LOWER: prdata = lower_q;
      raz_pkg::REG_GAIN:  prdata = {30'd0, gain_q};
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: everything advances unless the output buffer is full.
  // --------------------------------------------------------------------------
  logic en;
  logic skid_vld_q, out_vld_q;

  assign en         = ~skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // Stage 0: differences and magnitudes.
  logic          s0_vld_q, s0_zero_q, s0_sneg_q;
  logic [CB-1:0] s0_smag_q, s0_rmag_q;
  logic [CB:0]   sig_diff, ref_diff;
  logic [CB:0]   sig_neg_v, ref_neg_v;

  assign sig_diff  = {1'b0, signal_count_i} - {1'b0, signal_zero_count_i};
  assign ref_diff  = {1'b0, reference_count_i} - {1'b0, reference_zero_count_i};
  assign sig_neg_v = (CB+1)'(0) - sig_diff;
  assign ref_neg_v = (CB+1)'(0) - ref_diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_zero_q <= (ref_diff == '0);
      s0_sneg_q <= sig_diff[CB];
      s0_smag_q <= sig_diff[CB] ? sig_neg_v[CB-1:0] : sig_diff[CB-1:0];
      s0_rmag_q <= ref_diff[CB] ? ref_neg_v[CB-1:0] : ref_diff[CB-1:0];
    end
  end

  // Stage 1: magnitude product.
  raz_pkg::raz_tag_t s1_tag_q;
  logic [DW-1:0]     s1_prod_q;
  logic [CB-1:0]     s1_rmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else if (en) begin
      s1_tag_q.vld  <= s0_vld_q;
      s1_tag_q.zero <= s0_zero_q;
      s1_tag_q.neg  <= vneg_q ^ s0_sneg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= DW'(vmag_q) * DW'(s0_smag_q);
      s1_rmag_q <= s0_rmag_q;
    end
  end

  // Divider.
  raz_pkg::raz_tag_t dv_tag;
  logic [DW-1:0]     dv_quot;

  raz_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .tag_i      (s1_tag_q),
    .dividend_i (s1_prod_q),
    .divisor_i  (s1_rmag_q),
    .tag_o      (dv_tag),
    .quotient_o (dv_quot)
  );

  // Sign stage.
  raz_pkg::raz_tag_t     sg_tag_q;
  logic signed [QW-1:0]  sg_quot_q;
  logic [QW-1:0]         quot_ext;

  assign quot_ext = {1'b0, dv_quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_tag_q <= '0;
    end else if (en) begin
      sg_tag_q <= dv_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sg_quot_q <= dv_tag.neg ? (QW'(0) - quot_ext) : quot_ext;
    end
  end

  // Clamp stage: ceiling test first, floor test second.
  raz_pkg::raz_tag_t     cl_tag_q;
  logic signed [LW-1:0]  cl_val_q;
  logic signed [QW-1:0]  up_ext, lo_ext, r_up, r_lo;

  assign up_ext = QW'(upper_q);
  assign lo_ext = QW'(lower_q);
  assign r_up   = (sg_quot_q >= up_ext) ? up_ext : sg_quot_q;
  assign r_lo   = (r_up <= lo_ext) ? lo_ext : r_up;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_tag_q <= '0;
    end else if (en) begin
      cl_tag_q <= sg_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_val_q <= r_lo[LW-1:0];
    end
  end

  // Scale stage: times ten and hundred as shift-and-add.
  logic                 sc_vld_q, sc_zero_q;
  logic signed [VW-1:0] sc_val_q;
  logic signed [VW-1:0] rx, scaled;

  assign rx = VW'(cl_val_q);

  always_comb begin
    case (gain_q)
      raz_pkg::GAIN_ONE: scaled = rx;
      raz_pkg::GAIN_TEN: scaled = (rx <<< 3) + (rx <<< 1);
      default:           scaled = (rx <<< 6) + (rx <<< 5) + (rx <<< 2);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else if (en) begin
      sc_vld_q <= cl_tag_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_zero_q <= cl_tag_q.zero;
      sc_val_q  <= cl_tag_q.zero ? '0 : scaled;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid entry.
  // --------------------------------------------------------------------------
  logic                 out_zero_q, skid_zero_q;
  logic signed [VW-1:0] out_val_q, skid_val_q;
  logic                 out_free, tail_push;

  assign out_free  = ~out_vld_q | ~out_stall_i;
  assign tail_push = en & sc_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q | tail_push;
      skid_vld_q <= 1'b0;
    end else if (tail_push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_val_q  <= skid_val_q;
        out_zero_q <= skid_zero_q;
      end else begin
        out_val_q  <= sc_val_q;
        out_zero_q <= sc_zero_q;
      end
    end else if (tail_push) begin
      skid_val_q  <= sc_val_q;
      skid_zero_q <= sc_zero_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign value_o          = out_val_q;
  assign zero_reference_o = out_zero_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry holds a request while the output register is empty");

  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_zero_q) |-> (out_val_q == '0))
    else $error("zero reference result carries a nonzero value");

  a_hold_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> ($stable(sc_vld_q) && $stable(sc_val_q)))
    else $error("pipeline tail moved while the output buffer was full");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_stall_i) |=> (out_vld_q && !skid_vld_q))
    else $error("skid entry was lost or not moved to the output");

endmodule

@@ tb/tb_ratiometric_autozero_scaler_top.sv @@
// ----------------------------------------------------------------------------
// tb_ratiometric_autozero_scaler_top
// Self-checking bench for the ratiometric auto-zero scaler.
// ----------------------------------------------------------------------------
// Count sets go in through the valid/stall request port and every accepted
// request is turned into an expected reading by a local predictor. Results
// are compared in order, field by field. The register file is rewritten over
// several settings (defaults, full-scale, exact limits, crossed limits, every
// range group), each time with the pipeline drained. Both sides idle in
// random bursts except in the final phase.
// ----------------------------------------------------------------------------
module tb_ratiometric_autozero_scaler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned FRAC_W    = 20;
  localparam int unsigned VALUE_W   = raz_pkg::VALUE_W;
  localparam int unsigned PIPE_LAT  = COUNT_W + 38;
  localparam int unsigned PHASES    = 10;
  localparam int unsigned PHASE_LEN = 130;

  localparam logic [COUNT_W-1:0] CMAX = {COUNT_W{1'b1}};

  localparam longint UNIT = longint'(1) << FRAC_W;
  localparam logic [31:0] VREF_RESET  = 32'(-((28 * UNIT + 5) / 10));
  localparam logic [31:0] UPPER_RESET = 32'((32 * UNIT + 5) / 10);
  localparam logic [31:0] LOWER_RESET = 32'(-((32 * UNIT + 5) / 10));

  typedef struct packed {
    logic [COUNT_W-1:0] sig;
    logic [COUNT_W-1:0] sig_zero;
    logic [COUNT_W-1:0] ref_zero;
    logic [COUNT_W-1:0] ref_cnt;
  } count_set_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      zero_ref;
  } reading_t;

  typedef struct packed {
    logic [31:0] vref;
    logic [31:0] upper;
    logic [31:0] lower;
    logic [1:0]  gain;
  } setting_t;

  class raz_scoreboard;
    logic signed [31:0] vref;
    logic signed [31:0] upper;
    logic signed [31:0] lower;
    logic [1:0]         gain;
    reading_t           pending_readings[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        zero_refs;
    int unsigned        clamped;

    function new();
      vref  = VREF_RESET;
      upper = UPPER_RESET;
      lower = LOWER_RESET;
      gain  = raz_pkg::GAIN_ONE;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        raz_pkg::REG_VREF:  vref  = data;
        raz_pkg::REG_UPPER: upper = data;
        raz_pkg::REG_LOWER: lower = data;
        raz_pkg::REG_GAIN:  gain  = data[1:0];
        default: ;
      endcase
    endfunction

    // Scaled reading for one accepted count set, queued in arrival order.
    function void queue_scaled_reading(count_set_t cs);
      longint          sig_diff, span_diff, quot, rd;
      longint unsigned prod_mag, span_mag, quot_mag;
      bit              negative;
      reading_t        res;
      sig_diff  = longint'(cs.sig) - longint'(cs.sig_zero);
      span_diff = longint'(cs.ref_cnt) - longint'(cs.ref_zero);
      res = '0;
      if (span_diff == 0) begin
        res.zero_ref = 1'b1;
        zero_refs++;
      end else begin
        prod_mag = longint'(vref < 0 ? -longint'(vref) : longint'(vref)) *
                   (sig_diff < 0 ? -sig_diff : sig_diff);
        span_mag = span_diff < 0 ? -span_diff : span_diff;
        quot_mag = prod_mag / span_mag;
        negative = ((vref < 0) != (sig_diff < 0)) && quot_mag != 0;
        quot = negative ? -longint'(quot_mag) : longint'(quot_mag);
        // The ceiling is applied before the floor, which matters when the
        // limits are crossed.
        rd = quot;
        if (rd >= longint'(upper)) rd = longint'(upper);
        if (rd <= longint'(lower)) rd = longint'(lower);
        if (rd != quot) clamped++;
        if (gain == raz_pkg::GAIN_TEN) begin
          rd = rd * 10;
        end else if (gain != raz_pkg::GAIN_ONE) begin
          rd = rd * 100;
        end
        res.value = rd[VALUE_W-1:0];
      end
      pending_readings.push_back(res);
    endfunction

    function void check_reading(logic signed [VALUE_W-1:0] value, logic zero_ref);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $error("result with no request outstanding: value %0d zero_reference %0b",
               value, zero_ref);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      checked++;
      if (value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (zero_ref !== want.zero_ref) begin
        $error("zero_reference: expected %0b, actual %0b", want.zero_ref, zero_ref);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  count_set_t in_set = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [raz_pkg::PADDR_W-1:0] paddr = '0;
  logic [raz_pkg::PDATA_W-1:0] pwdata = '0;
  logic calm = 1'b0;

  logic                              in_stall_o;
  logic                              out_valid_o;
  logic signed [VALUE_W-1:0]         value_o;
  logic                              zero_reference_o;
  logic [raz_pkg::PDATA_W-1:0]       prdata;
  logic                              pready;

  raz_scoreboard sb = new();

  ratiometric_autozero_scaler_top #(
    .COUNT_BITS   (COUNT_W),
    .FRACTION_BITS(FRAC_W)
  ) i_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall_o),
    .signal_count_i        (in_set.sig),
    .signal_zero_count_i   (in_set.sig_zero),
    .reference_zero_count_i(in_set.ref_zero),
    .reference_count_i     (in_set.ref_cnt),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall),
    .value_o               (value_o),
    .zero_reference_o      (zero_reference_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_ni && in_valid && !in_stall_o) sb.queue_scaled_reading(in_set);
    if (rst_ni && out_valid_o && !out_stall) sb.check_reading(value_o, zero_reference_o);
  end

  // Receiver stalls in random bursts until the final phase.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge after acceptance, now and then after an idle burst.
  task automatic send_count_set(count_set_t cs);
    in_valid = 1'b1;
    in_set   = cs;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic drain_readings();
    in_valid = 1'b0;
    while (sb.pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_setting(setting_t st);
    drain_readings();
    write_register(raz_pkg::REG_VREF, st.vref);
    write_register(raz_pkg::REG_UPPER, st.upper);
    write_register(raz_pkg::REG_LOWER, st.lower);
    write_register(raz_pkg::REG_GAIN, {30'd0, st.gain});
  endtask

  function automatic setting_t random_setting();
    setting_t st;
    int       a, b;
    st.vref = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 16 << 20) - (8 << 20);
    a = $urandom_range(0, 3) == 0 ? int'($urandom)
                                  : int'($urandom_range(0, 16 << 20) - (8 << 20));
    b = int'($urandom_range(0, 16 << 20) - (8 << 20));
    // Mostly ordered limits, now and then left crossed.
    if ($urandom_range(0, 3) != 0 && a < b) begin
      st.upper = b;
      st.lower = a;
    end else begin
      st.upper = a;
      st.lower = b;
    end
    st.gain = 2'($urandom_range(0, 3));
    return st;
  endfunction

  function automatic count_set_t random_count_set();
    count_set_t cs;
    logic [COUNT_W-1:0] t;
    int unsigned        mode;
    mode = $urandom_range(0, 9);
    cs.sig      = COUNT_W'($urandom);
    cs.sig_zero = COUNT_W'($urandom);
    cs.ref_zero = COUNT_W'($urandom);
    cs.ref_cnt  = COUNT_W'($urandom);
    case (mode)
      0: ;
      1: cs.ref_cnt = cs.ref_zero;
      2, 3, 4: begin
        // Realistic conversion: small zeros, large reference span.
        cs.ref_zero = COUNT_W'($urandom_range(0, 1 << 20));
        cs.ref_cnt  = COUNT_W'(cs.ref_zero + $urandom_range(1, 1 << 23));
        cs.sig_zero = COUNT_W'($urandom_range(0, 1 << 20));
        cs.sig      = COUNT_W'(cs.sig_zero + $urandom_range(0, 1 << 23));
        if ($urandom_range(0, 1)) begin
          t = cs.sig; cs.sig = cs.sig_zero; cs.sig_zero = t;
        end
        if ($urandom_range(0, 3) == 0) begin
          t = cs.ref_cnt; cs.ref_cnt = cs.ref_zero; cs.ref_zero = t;
        end
      end
      5: begin
        // Signal span equal to the reference span, either sign.
        cs.ref_zero = COUNT_W'($urandom_range(0, 1 << 22));
        cs.ref_cnt  = COUNT_W'(cs.ref_zero + $urandom_range(1, 1 << 22));
        cs.sig_zero = COUNT_W'($urandom_range(0, 1 << 22));
        cs.sig      = cs.sig_zero + (cs.ref_cnt - cs.ref_zero);
        if ($urandom_range(0, 1)) begin
          t = cs.sig; cs.sig = cs.sig_zero; cs.sig_zero = t;
        end
      end
      6: begin
        cs.sig      = $urandom_range(0, 1) ? CMAX : '0;
        cs.sig_zero = $urandom_range(0, 1) ? CMAX : COUNT_W'($urandom_range(0, 3));
        cs.ref_zero = $urandom_range(0, 1) ? COUNT_W'(CMAX - $urandom_range(0, 3)) : '0;
        cs.ref_cnt  = $urandom_range(0, 1) ? CMAX : COUNT_W'($urandom_range(0, 3));
      end
      7: begin
        cs.sig      = COUNT_W'($urandom_range(0, 15));
        cs.sig_zero = COUNT_W'($urandom_range(0, 15));
        cs.ref_zero = COUNT_W'($urandom_range(0, 15));
        cs.ref_cnt  = COUNT_W'($urandom_range(0, 15));
      end
      8: cs.sig = cs.sig_zero;
      default: cs.ref_cnt = COUNT_W'(cs.ref_zero + $urandom_range(1, 8));
    endcase
    return cs;
  endfunction

  initial begin
    setting_t plan[PHASES];
    plan[0] = '{VREF_RESET, UPPER_RESET, LOWER_RESET, raz_pkg::GAIN_ONE};
    plan[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, raz_pkg::GAIN_ONE};
    plan[2] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, raz_pkg::GAIN_HUNDRED};
    plan[3] = '{32'h0010_0000, 32'h0010_0000, 32'hFFF0_0000, raz_pkg::GAIN_TEN};
    plan[4] = '{32'h0030_0000, 32'hFFF0_0000, 32'h0010_0000, raz_pkg::GAIN_SATURATE};
    plan[5] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, raz_pkg::GAIN_TEN};
    for (int p = 6; p < PHASES; p++) plan[p] = random_setting();

    repeat (10) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Reset values first, starting with the corner cases.
    send_count_set('{24'd0, 24'd0, 24'd0, 24'd0});
    send_count_set('{CMAX, CMAX, CMAX, CMAX});
    send_count_set('{24'h5A5A5A, 24'h123456, 24'hA5A5A5, 24'hA5A5A5});
    send_count_set('{CMAX, 24'd0, 24'd0, CMAX});
    send_count_set('{24'd0, CMAX, 24'd0, CMAX});
    send_count_set('{CMAX, 24'd0, CMAX, 24'd0});
    send_count_set('{CMAX, 24'd0, 24'd0, 24'd1});
    send_count_set('{24'd0, CMAX, 24'd0, 24'd1});
    send_count_set('{24'h400000, 24'h400000, 24'd0, CMAX});
    send_count_set('{24'd1, 24'd0, 24'd0, 24'd3});
    send_count_set('{24'd0, 24'd1, 24'd0, 24'd3});
    send_count_set('{24'd1, 24'd0, 24'd3, 24'd0});
    send_count_set('{24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA});
    send_count_set('{24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555});
    send_count_set('{24'h100000, 24'd0, 24'd0, 24'h100000});
    send_count_set('{24'h200000, 24'h100000, 24'h080000, 24'h180000});

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) apply_setting(plan[p]);
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) send_count_set(random_count_set());
    end

    drain_readings();
    repeat (PIPE_LAT + 10) @(negedge clk);
    while (sb.pending_readings.size() != 0) begin
      void'(sb.pending_readings.pop_front());
      $error("reading still outstanding at end of run");
      sb.errors++;
    end

    $display("Checked %0d readings over %0d register settings and all four range groups.",
             sb.checked, PHASES);
    $display("Of these, %0d had a zero reference span and %0d were clamped.",
             sb.zero_refs, sb.clamped);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
